[rtl/bsd_pkg.sv]
`timescale 1ns / 1ps

package bsd_pkg;

  localparam int DEFAULT_MAX_FRAME = 2048;

  localparam int LEN_W  = 12;
  localparam int CNT_W  = 32;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  localparam logic [7:0] SYNC_RESET        = 8'h7e;
  localparam logic [7:0] ESCAPE_RESET      = 8'h7d;
  localparam logic [7:0] ESC_SYNC_RESET    = 8'h5e;
  localparam logic [7:0] ESC_ESCAPE_RESET  = 8'h5d;

  typedef enum logic [1:0] {
    REG_SYNC       = 2'd0,
    REG_ESCAPE     = 2'd1,
    REG_ESC_SYNC   = 2'd2,
    REG_ESC_ESCAPE = 2'd3
  } reg_idx_t;

  typedef enum logic {
    KIND_BYTE  = 1'b0,
    KIND_RESET = 1'b1
  } in_kind_t;

  typedef enum logic {
    OUT_DATA = 1'b0,
    OUT_END  = 1'b1
  } out_kind_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
    logic       abort_rx;
    logic       clear_rx;
  } in_item_t;

  typedef struct packed {
    logic [7:0] sync_char;
    logic [7:0] escape_char;
    logic [7:0] escaped_sync_code;
    logic [7:0] escaped_escape_code;
  } cfg_t;

  typedef struct packed {
    logic             out_kind;
    logic [7:0]       out_byte;
    logic [LEN_W-1:0] frame_length;
    logic             bad_escape_end;
    logic             overflowed;
    logic [CNT_W-1:0] frames_received;
    logic [CNT_W-1:0] out_of_frame_bytes;
    logic             last;
  } result_t;

  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } push_t;

endpackage

[rtl/bsd_regs.sv]
`timescale 1ns / 1ps

module bsd_regs
  import bsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_char           <= SYNC_RESET;
      cfg.escape_char         <= ESCAPE_RESET;
      cfg.escaped_sync_code   <= ESC_SYNC_RESET;
      cfg.escaped_escape_code <= ESC_ESCAPE_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_SYNC:       cfg.sync_char           <= pwdata[7:0];
        REG_ESCAPE:     cfg.escape_char         <= pwdata[7:0];
        REG_ESC_SYNC:   cfg.escaped_sync_code   <= pwdata[7:0];
        REG_ESC_ESCAPE: cfg.escaped_escape_code <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SYNC:       prdata = {24'd0, cfg.sync_char};
      REG_ESCAPE:     prdata = {24'd0, cfg.escape_char};
      REG_ESC_SYNC:   prdata = {24'd0, cfg.escaped_sync_code};
      REG_ESC_ESCAPE: prdata = {24'd0, cfg.escaped_escape_code};
      default:        prdata = '0;
    endcase
  end

endmodule

[rtl/bsd_decode.sv]
`timescale 1ns / 1ps

module bsd_decode
  import bsd_pkg::*;
#(
  parameter int MAX_FRAME = DEFAULT_MAX_FRAME
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  in_item_t s_item,
  input  cfg_t     cfg,
  input  logic     space_ok,
  output push_t    push
);

  localparam int CW = $clog2(MAX_FRAME + 1);

  logic             in_valid;
  in_item_t         in_item;
  logic             consume;

  logic             in_frame;
  logic             escape_pending;
  logic [CW-1:0]    byte_count;
  logic             overflow_seen;
  logic [CNT_W-1:0] frame_counter;
  logic [CNT_W-1:0] hunt_byte_counter;

  logic             in_frame_next;
  logic             escape_pending_next;
  logic [CW-1:0]    byte_count_next;
  logic             overflow_seen_next;
  logic [CNT_W-1:0] frame_counter_next;
  logic [CNT_W-1:0] hunt_byte_counter_next;

  logic             store_req;
  logic [7:0]       store_val;
  logic             store_ok;
  logic             end_req;
  logic             end_bad;
  logic [CW-1:0]    count_st;
  logic             ovf_st;

  assign consume  = in_valid && space_ok;
  assign s_tready = !in_valid || consume;

  always_comb begin
    in_frame_next          = in_frame;
    escape_pending_next    = escape_pending;
    hunt_byte_counter_next = hunt_byte_counter;
    store_req              = 1'b0;
    store_val              = in_item.rx_byte;
    end_req                = 1'b0;
    end_bad                = 1'b0;

    if (in_item.kind == KIND_RESET) begin
      if (in_item.abort_rx) begin
        in_frame_next       = 1'b0;
        escape_pending_next = 1'b0;
      end
    end else if (!in_frame) begin
      if (in_item.rx_byte == cfg.sync_char) begin
        in_frame_next = 1'b1;
      end else begin
        hunt_byte_counter_next = hunt_byte_counter + 1'b1;
      end
    end else if (escape_pending) begin
      escape_pending_next = 1'b0;
      store_req           = 1'b1;
      if (in_item.rx_byte == cfg.escaped_sync_code) begin
        store_val = cfg.sync_char;
      end else if (in_item.rx_byte == cfg.escaped_escape_code) begin
        store_val = cfg.escape_char;
      end else begin
        store_val = cfg.sync_char;
        end_req   = 1'b1;
        end_bad   = 1'b1;
      end
    end else if (in_item.rx_byte == cfg.escape_char) begin
      escape_pending_next = 1'b1;
    end else if (in_item.rx_byte == cfg.sync_char) begin
      end_req = (byte_count != '0);
    end else begin
      store_req = 1'b1;
    end

    store_ok = store_req && (byte_count < CW'(MAX_FRAME));
    count_st = store_ok ? CW'(byte_count + 1'b1) : byte_count;
    ovf_st   = overflow_seen || (store_req && !store_ok);

    frame_counter_next = end_req ? frame_counter + 1'b1 : frame_counter;
    if (end_req) begin
      in_frame_next = 1'b0;
    end

    if (in_item.kind == KIND_RESET && in_item.clear_rx) begin
      byte_count_next    = '0;
      overflow_seen_next = 1'b0;
    end else if (end_req) begin
      byte_count_next    = '0;
      overflow_seen_next = 1'b0;
    end else begin
      byte_count_next    = count_st;
      overflow_seen_next = ovf_st;
    end

    push.res0.out_kind           = store_ok ? OUT_DATA : OUT_END;
    push.res0.out_byte           = store_ok ? store_val : 8'd0;
    push.res0.frame_length       = store_ok ? '0 : LEN_W'(count_st);
    push.res0.bad_escape_end     = !store_ok && end_bad;
    push.res0.overflowed         = !store_ok && ovf_st;
    push.res0.frames_received    = store_ok ? frame_counter : frame_counter_next;
    push.res0.out_of_frame_bytes = hunt_byte_counter_next;
    push.res0.last               = !(store_ok && end_req);

    push.res1.out_kind           = OUT_END;
    push.res1.out_byte           = 8'd0;
    push.res1.frame_length       = LEN_W'(count_st);
    push.res1.bad_escape_end     = end_bad;
    push.res1.overflowed         = ovf_st;
    push.res1.frames_received    = frame_counter_next;
    push.res1.out_of_frame_bytes = hunt_byte_counter_next;
    push.res1.last               = 1'b1;

    push.push0 = consume && (store_ok || end_req);
    push.push1 = consume && store_ok && end_req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid          <= 1'b0;
      in_frame          <= 1'b0;
      escape_pending    <= 1'b0;
      byte_count        <= '0;
      overflow_seen     <= 1'b0;
      frame_counter     <= '0;
      hunt_byte_counter <= '0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (consume) begin
        in_frame          <= in_frame_next;
        escape_pending    <= escape_pending_next;
        byte_count        <= byte_count_next;
        overflow_seen     <= overflow_seen_next;
        frame_counter     <= frame_counter_next;
        hunt_byte_counter <= hunt_byte_counter_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= s_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CW'(MAX_FRAME))
    else $error("frame byte count above limit");

  a_escape_in_frame: assert property (@(posedge clk) disable iff (rst)
    escape_pending |-> in_frame)
    else $error("escape pending while hunting");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |-> (byte_count == CW'(MAX_FRAME)))
    else $error("overflow flagged on a frame that is not full");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push.push1 |-> (push.push0 && push.res0.out_kind == OUT_DATA && !push.res0.last))
    else $error("second result without a data result ahead of it");

endmodule

[rtl/bsd_queue.sv]
`timescale 1ns / 1ps

module bsd_queue
  import bsd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    space_ok,
  output logic    m_tvalid,
  input  logic    m_tready,
  output result_t head
);

  result_t          mem [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr;
  logic [Q_AW-1:0]  rd_ptr;
  logic [Q_CW-1:0]  count;
  logic [Q_CW-1:0]  count_next;
  logic             pop;

  assign m_tvalid = (count != '0);
  assign head     = mem[rd_ptr];
  assign pop      = m_tvalid && m_tready;
  assign space_ok = (count <= Q_CW'(Q_DEPTH - 2));

  assign count_next = count + Q_CW'(push.push0) + Q_CW'(push.push1) - Q_CW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push.push1) begin
        wr_ptr <= wr_ptr + Q_AW'(2);
      end else if (push.push0) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem[wr_ptr] <= push.res0;
    end
    if (push.push1) begin
      mem[wr_ptr + 1'b1] <= push.res1;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CW'(Q_DEPTH))
    else $error("result queue overrun");

endmodule

[rtl/byte_stuffing_deframer_core.sv]
`timescale 1ns / 1ps
// channel   direction  handshake            payload
// s_*       in         s_tvalid / s_tready  tuser kind, tdata rx_byte, abort_rx, clear_rx
// m_*       out        m_tvalid / m_tready  tuser out_kind, tlast last, tdata result fields
// apb       in         psel/penable/pready  four 8-bit delimiter and escape registers
//
// one byte per cycle while s_tready is high; a byte is held in the input register, and its
// results (zero, one or two) enter a four-entry result queue once the queue has room
// a byte that ends a frame on a bad escape yields two results unless the frame is full;
// the output drains one result per cycle while m_tready is high, as the input takes bytes
// s_tready falls only while the result queue holds more than two results
// synchronous reset clears control state and counters at once, no clearing pass

module byte_stuffing_deframer_core
  import bsd_pkg::*;
#(
  parameter int MAX_FRAME = DEFAULT_MAX_FRAME
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,  // rx_byte, abort_rx, clear_rx, zero pad
  input  logic              s_tuser,  // kind
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [87:0]       m_tdata,  // out_byte, frame_length, bad_escape_end,
                                      // overflowed, frames_received,
                                      // out_of_frame_bytes, zero pad
  output logic              m_tuser,  // out_kind
  output logic              m_tlast,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t     cfg;
  in_item_t s_item;
  push_t    push;
  logic     space_ok;
  result_t  head;

  assign s_item.kind     = s_tuser;
  assign s_item.rx_byte  = s_tdata[7:0];
  assign s_item.abort_rx = s_tdata[8];
  assign s_item.clear_rx = s_tdata[9];

  bsd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bsd_decode #(
    .MAX_FRAME (MAX_FRAME)
  ) u_decode (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_item   (s_item),
    .cfg      (cfg),
    .space_ok (space_ok),
    .push     (push)
  );

  bsd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .space_ok (space_ok),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .head     (head)
  );

  assign m_tuser = head.out_kind;
  assign m_tlast = head.last;
  assign m_tdata = {2'b00, head.out_of_frame_bytes, head.frames_received,
                    head.overflowed, head.bad_escape_end, head.frame_length,
                    head.out_byte};

endmodule

[tb/byte_stuffing_deframer_core_test.sv]
`timescale 1ns / 1ps

module byte_stuffing_deframer_core_test;
  import bsd_pkg::*;

  localparam int MAX_FRAME   = DEFAULT_MAX_FRAME;
  localparam int CYCLE_LIMIT = 1_000_000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [15:0]       s_tdata = '0;  // rx_byte, abort_rx, clear_rx, zero pad
  logic              s_tuser = 1'b0;  // kind
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [87:0]       m_tdata;  // out_byte, frame_length, bad_escape_end, overflowed,
                               // frames_received, out_of_frame_bytes, zero pad
  logic              m_tuser;  // out_kind
  logic              m_tlast;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  cfg_t        cfg_now = '{SYNC_RESET, ESCAPE_RESET, ESC_SYNC_RESET, ESC_ESCAPE_RESET};
  logic        rx_in_frame = 1'b0;
  logic        rx_escape_pending = 1'b0;
  int          rx_byte_count = 0;
  logic        rx_overflow = 1'b0;
  logic [31:0] frames_done = '0;
  logic [31:0] hunt_bytes = '0;

  result_t     step_out[$];
  result_t     expected_results[$];

  logic        gaps_on = 1'b1;
  logic        stalls_on = 1'b1;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned bad_ends = 0;
  int unsigned overflow_ends = 0;
  int unsigned settings_applied = 0;
  int unsigned cycle_count = 0;

  byte_stuffing_deframer_core #(.MAX_FRAME(MAX_FRAME)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("byte_stuffing_deframer_core_test: FAIL");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic emit_data(input logic [7:0] b);
    result_t r;
    if (rx_byte_count < MAX_FRAME) begin
      rx_byte_count++;
      r = '0;
      r.out_kind = OUT_DATA;
      r.out_byte = b;
      r.frames_received = frames_done;
      r.out_of_frame_bytes = hunt_bytes;
      step_out.push_back(r);
    end else begin
      rx_overflow = 1'b1;
    end
  endtask

  task automatic close_frame(input logic bad);
    result_t r;
    frames_done++;
    r = '0;
    r.out_kind = OUT_END;
    r.frame_length = LEN_W'(rx_byte_count);
    r.bad_escape_end = bad;
    r.overflowed = rx_overflow;
    r.frames_received = frames_done;
    r.out_of_frame_bytes = hunt_bytes;
    step_out.push_back(r);
    if (bad) bad_ends++;
    if (rx_overflow) overflow_ends++;
    rx_byte_count = 0;
    rx_overflow = 1'b0;
    rx_in_frame = 1'b0;
  endtask

  task automatic deframe_step(input in_item_t it);
    result_t r;
    logic [7:0] b;
    b = it.rx_byte;
    step_out.delete();
    if (it.kind == KIND_RESET) begin
      if (it.abort_rx) begin
        rx_in_frame = 1'b0;
        rx_escape_pending = 1'b0;
      end
      if (it.clear_rx) begin
        rx_byte_count = 0;
        rx_overflow = 1'b0;
      end
    end else if (!rx_in_frame) begin
      if (b == cfg_now.sync_char) rx_in_frame = 1'b1;
      else hunt_bytes++;
    end else if (rx_escape_pending) begin
      rx_escape_pending = 1'b0;
      if (b == cfg_now.escaped_sync_code) begin
        emit_data(cfg_now.sync_char);
      end else if (b == cfg_now.escaped_escape_code) begin
        emit_data(cfg_now.escape_char);
      end else begin
        emit_data(cfg_now.sync_char);
        close_frame(1'b1);
      end
    end else if (b == cfg_now.escape_char) begin
      rx_escape_pending = 1'b1;
    end else if (b == cfg_now.sync_char) begin
      if (rx_byte_count > 0) close_frame(1'b0);
    end else begin
      emit_data(b);
    end
    foreach (step_out[i]) begin
      r = step_out[i];
      r.last = (i == step_out.size() - 1);
      expected_results.push_back(r);
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t seen;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      seen.out_kind = m_tuser;
      seen.out_byte = m_tdata[7:0];
      seen.frame_length = m_tdata[19:8];
      seen.bad_escape_end = m_tdata[20];
      seen.overflowed = m_tdata[21];
      seen.frames_received = m_tdata[53:22];
      seen.out_of_frame_bytes = m_tdata[85:54];
      seen.last = m_tlast;
      if (expected_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result transfer kind=%0d byte=%02h len=%0d",
                                seen.out_kind, seen.out_byte, seen.frame_length));
      end else begin
        want = expected_results.pop_front();
        if (seen !== want)
          flag_mismatch($sformatf({"result %0d\n  exp kind=%0d byte=%02h len=%0d bad=%0d ",
                                   "ovf=%0d frames=%0d hunt=%0d last=%0d\n  got kind=%0d ",
                                   "byte=%02h len=%0d bad=%0d ovf=%0d frames=%0d hunt=%0d ",
                                   "last=%0d"}, results_seen,
                                  want.out_kind, want.out_byte, want.frame_length,
                                  want.bad_escape_end, want.overflowed,
                                  want.frames_received, want.out_of_frame_bytes, want.last,
                                  seen.out_kind, seen.out_byte, seen.frame_length,
                                  seen.bad_escape_end, seen.overflowed,
                                  seen.frames_received, seen.out_of_frame_bytes, seen.last));
      end
    end
  end

  initial begin : result_sink
    int unsigned hold;
    while (rst) @(posedge clk);
    m_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        hold = stalls_on ? $urandom_range(0, 14) : 0;
        if (hold != 0) begin
          m_tready <= 1'b0;
          repeat (hold) @(posedge clk);
          m_tready <= 1'b1;
        end
      end
    end
  end

  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.kind;
    s_tdata <= {6'b0, it.clear_rx, it.abort_rx, it.rx_byte};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    deframe_step(it);
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_item_t it;
    it.kind = KIND_BYTE;
    it.rx_byte = b;
    it.abort_rx = 1'($urandom_range(0, 1));
    it.clear_rx = 1'($urandom_range(0, 1));
    send_item(it);
  endtask

  task automatic send_cmd(input logic abort, input logic clear);
    in_item_t it;
    it.kind = KIND_RESET;
    it.rx_byte = 8'($urandom_range(0, 255));
    it.abort_rx = abort;
    it.clear_rx = clear;
    send_item(it);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
    logic [DATA_W-1:0] rd;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_SYNC:       cfg_now.sync_char = val;
      REG_ESCAPE:     cfg_now.escape_char = val;
      REG_ESC_SYNC:   cfg_now.escaped_sync_code = val;
      REG_ESC_ESCAPE: cfg_now.escaped_escape_code = val;
    endcase
    if (rd[7:0] !== val)
      flag_mismatch($sformatf("register %s read back %02h, wrote %02h", idx.name(),
                              rd[7:0], val));
  endtask

  task automatic set_config(input logic [7:0] s, e, cs, ce);
    wait_drained();
    write_reg(REG_SYNC, s);
    write_reg(REG_ESCAPE, e);
    write_reg(REG_ESC_SYNC, cs);
    write_reg(REG_ESC_ESCAPE, ce);
    settings_applied++;
  endtask

  function automatic logic [7:0] plain_byte();
    return 8'($urandom_range(0, 8'h7c));
  endfunction

  // optional hunting noise and a random item, a stuffed frame with random content, then a random way out
  task automatic send_random_frame();
    int unsigned n;
    logic [7:0] b;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 9) == 0) send_item(in_item_t'(11'($urandom_range(0, 2047))));
    send_byte(cfg_now.sync_char);
    n = $urandom_range(0, 12);
    repeat (n) begin
      if ($urandom_range(0, 4) == 0)
        b = ($urandom_range(0, 1) != 0) ? cfg_now.sync_char : cfg_now.escape_char;
      else
        b = 8'($urandom_range(0, 255));
      if (b == cfg_now.sync_char || b == cfg_now.escape_char) begin
        send_byte(cfg_now.escape_char);
        send_byte(b == cfg_now.sync_char ? cfg_now.escaped_sync_code
                                         : cfg_now.escaped_escape_code);
      end else begin
        send_byte(b);
      end
      if ($urandom_range(0, 19) == 0)
        send_cmd(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    case ($urandom_range(0, 9))
      0: begin
        send_byte(cfg_now.escape_char);
        send_byte(8'($urandom_range(0, 255)));
      end
      1: send_cmd(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      default: send_byte(cfg_now.sync_char);
    endcase
  endtask

  task automatic test_directed();
    send_byte(8'h00);
    send_cmd(1'b0, 1'b0);
    send_byte(SYNC_RESET);
    send_byte(SYNC_RESET);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(ESCAPE_RESET);
    send_byte(ESC_SYNC_RESET);
    send_byte(ESCAPE_RESET);
    send_byte(ESC_ESCAPE_RESET);
    send_byte(SYNC_RESET);
    send_byte(SYNC_RESET);
    send_byte(8'h41);
    send_byte(ESCAPE_RESET);
    send_byte(8'h33);
    send_byte(SYNC_RESET);
    send_byte(8'h42);
    send_cmd(1'b1, 1'b0);
    send_byte(SYNC_RESET);
    send_byte(8'h43);
    send_cmd(1'b0, 1'b1);
    send_byte(8'h44);
    send_byte(SYNC_RESET);
    send_byte(SYNC_RESET);
    send_byte(ESCAPE_RESET);
    send_cmd(1'b1, 1'b1);
    send_byte(SYNC_RESET);
    send_byte(8'h45);
    send_byte(SYNC_RESET);
  endtask

  // one frame past the limit closed by a bad escape, then a count clear mid frame
  task automatic test_overflow();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    send_byte(cfg_now.sync_char);
    repeat (MAX_FRAME + 1) send_byte(plain_byte());
    send_byte(cfg_now.escape_char);
    send_byte(8'h00);
    send_byte(cfg_now.sync_char);
    repeat (2) send_byte(plain_byte());
    send_cmd(1'b0, 1'b1);
    repeat (2) send_byte(plain_byte());
    send_byte(cfg_now.sync_char);
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  task automatic test_config_extremes();
    set_config(8'h00, 8'h00, 8'h00, 8'h00);
    repeat (8) send_random_frame();
    set_config(8'hff, 8'hff, 8'hff, 8'hff);
    repeat (8) send_random_frame();
    set_config(8'h55, 8'h55, 8'h01, 8'h02);
    repeat (8) send_random_frame();
    set_config(8'h7e, 8'h7d, 8'h20, 8'h20);
    repeat (8) send_random_frame();
    set_config(8'h00, 8'hff, 8'hff, 8'h00);
    repeat (8) send_random_frame();
  endtask

  task automatic test_random();
    int unsigned start;
    int unsigned pauses;
    start = items_sent;
    pauses = 0;
    for (int phase = 0; phase < 4; phase++) begin
      set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      while (items_sent - start < (phase + 1) * 200) begin
        gaps_on = ($urandom_range(0, 5) != 0);
        stalls_on = ($urandom_range(0, 5) != 0);
        send_random_frame();
        if (phase == 1 && pauses == 0 && items_sent - start >= 300) begin
          wait_drained();
          pauses++;
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_config_extremes();
    test_random();
    wait_drained();
    $display("covered %0d input transfers and %0d result transfers over %0d register settings",
             items_sent, results_seen, settings_applied);
    $display("frames closed: %0d, of which %0d on a bad escape and %0d after overflow",
             frames_done, bad_ends, overflow_ends);
    if (mismatches == 0) begin
      $display("byte_stuffing_deframer_core_test: PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("byte_stuffing_deframer_core_test: FAIL");
    end
    $finish;
  end

endmodule
